// ===== src/scgi_tok_pkg.sv =====
// Package for the SCGI header tokenizer: item types, codes and constants.
// No dependencies; used by scgi_header_tokenizer_top.
package scgi_tok_pkg;

  // Width of the length accumulator and of the body byte counter
  localparam int LENGTH_BITS = 14;
  localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};
  // Width used when comparing the parsed length against max_body_length
  localparam int MAX_BODY_W = 14;
  localparam int LEN_CMP_W = (LENGTH_BITS > MAX_BODY_W) ? LENGTH_BITS : MAX_BODY_W;

  // Configuration port
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 14;
  localparam int MAX_CHARS_W = 5;

  // Result queue
  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_AW = 3;
  localparam int FIFO_CNT_W = 4;
  localparam int MAX_RESULTS = 3;

  // Reset values of the configuration registers
  localparam logic [MAX_BODY_W-1:0] MAX_BODY_RESET = 14'd10239;
  localparam logic [MAX_CHARS_W-1:0] MAX_CHARS_RESET = 5'd20;

  // Characters of interest
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_PCT = 8'h25;
  localparam logic [7:0] CH_TWO = 8'h32;
  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_NINE = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_NUL = 8'h00;

  typedef enum logic [1:0] {
    PH_LEN  = 2'd0,
    PH_BODY = 2'd1,
    PH_DONE = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_PCT  = 2'd1,
    ESC_PCT2 = 2'd2
  } esc_t;

  typedef enum logic [2:0] {
    K_NAME_BYTE  = 3'd0,
    K_NAME_END   = 3'd1,
    K_VALUE_BYTE = 3'd2,
    K_VALUE_END  = 3'd3,
    K_ACCEPT     = 3'd4,
    K_REJECT     = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ERR_FIELD_LONG = 2'd0,
    ERR_OVER_LIMIT = 2'd1,
    ERR_NO_COMMA   = 2'd2
  } err_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_BODY_LENGTH  = 2'd0,
    CFG_MAX_LENGTH_CHARS = 2'd1,
    CFG_DECODE_SPACE     = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       new_request;
  } in_item_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       last;
  } out_item_t;

  // Build one result with last cleared
  function automatic out_item_t mk_res(kind_t k, logic [7:0] b, err_t e);
    out_item_t r;
    r.kind = k;
    r.out_byte = b;
    r.error_code = e;
    r.last = 1'b0;
    return r;
  endfunction

endpackage

// ===== src/scgi_header_tokenizer_top.sv =====
// SCGI header tokenizer top level: length parser, body tokenizer, result queue.
// Depends on scgi_tok_pkg.
//
// Takes one header byte per accepted item and parses it combinationally:
// the byte is decoded against the parser state registers and its zero to
// three results are written into an 8-entry result queue in the same clock,
// from which they appear on out_* once earlier queued results have drained.
// in_ready is high whenever the queue has at least three free entries, so a
// new byte can be taken every cycle while that holds; the output side drains
// one result per cycle while out_ready is high (a byte can give up to three
// results, such as a NUL after a held "%2"). Configuration writes are
// registered and affect the bytes accepted after the write.
module scgi_header_tokenizer_top
  import scgi_tok_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  // input items
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  // result items
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  logic [MAX_BODY_W-1:0]  max_body_r;
  logic [MAX_CHARS_W-1:0] max_chars_r;
  logic                   decode_r;

  // Parser state
  phase_t                 phase_r, phase_nxt;
  logic [LENGTH_BITS-1:0] lval_r, lval_nxt;
  logic [4:0]             lchars_r, lchars_nxt;
  logic                   linv_r, linv_nxt;
  logic [LENGTH_BITS-1:0] left_r, left_nxt;
  logic                   inval_r, inval_nxt;
  logic                   named_r, named_nxt;
  esc_t                   esc_r, esc_nxt;

  // State as seen by this byte, after an optional new_request clear
  phase_t                 eff_phase;
  logic [LENGTH_BITS-1:0] eff_lval;
  logic [4:0]             eff_lchars;
  logic                   eff_linv;
  logic [LENGTH_BITS-1:0] eff_left;
  logic                   eff_inval;
  logic                   eff_named;
  esc_t                   eff_esc;

  // Result queue
  out_item_t              fifo_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0]  cnt_r, cnt_nxt;

  // Per-byte results
  out_item_t              res [MAX_RESULTS];
  logic [1:0]             res_n;

  logic                   in_acc, out_acc;
  logic [7:0]             b;
  logic                   len_full, is_colon, is_digit, len_reject, body_last;
  logic [LENGTH_BITS-1:0] len_eff, lval_sat;
  logic [LENGTH_BITS+3:0] lval_wide;

  assign in_acc    = in_valid && in_ready;
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = cnt_r <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS);
  assign out_valid = cnt_r != '0;
  assign out_data  = fifo_r[rd_ptr_r];
  assign b         = in_data.data_byte;

  // Effective state after new_request
  always_comb begin
    if (in_data.new_request) begin
      eff_phase  = PH_LEN;
      eff_lval   = '0;
      eff_lchars = '0;
      eff_linv   = 1'b0;
      eff_left   = '0;
      eff_inval  = 1'b0;
      eff_named  = 1'b0;
      eff_esc    = ESC_NONE;
    end else begin
      eff_phase  = phase_r;
      eff_lval   = lval_r;
      eff_lchars = lchars_r;
      eff_linv   = linv_r;
      eff_left   = left_r;
      eff_inval  = inval_r;
      eff_named  = named_r;
      eff_esc    = esc_r;
    end
  end

  // Byte decode and length arithmetic (x*10 as two shifts and an add)
  always_comb begin
    len_full   = eff_lchars >= max_chars_r;
    is_colon   = b == CH_COLON;
    is_digit   = (b >= CH_ZERO) && (b <= CH_NINE);
    len_eff    = eff_linv ? '0 : eff_lval;
    len_reject = LEN_CMP_W'(len_eff) > LEN_CMP_W'(max_body_r);
    body_last  = eff_left == '0;
    lval_wide  = {eff_lval, 3'b000} + {2'b00, eff_lval, 1'b0}
                 + (LENGTH_BITS+4)'(b[3:0]);
    lval_sat   = (lval_wide > (LENGTH_BITS+4)'(LEN_MAX)) ? LEN_MAX
                 : lval_wide[LENGTH_BITS-1:0];
  end

  // Next phase
  always_comb begin
    phase_nxt = eff_phase;
    case (eff_phase)
      PH_LEN: begin
        if (len_full) begin
          phase_nxt = PH_DONE;
        end else if (is_colon) begin
          phase_nxt = len_reject ? PH_DONE : PH_BODY;
        end
      end
      PH_BODY: begin
        if (body_last) begin
          phase_nxt = PH_DONE;
        end
      end
      default: phase_nxt = eff_phase;
    endcase
  end

  // Results and datapath state for this byte
  always_comb begin
    logic done;
    esc_t e;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    res_n      = '0;
    done       = 1'b0;
    e          = eff_esc;
    lval_nxt   = eff_lval;
    lchars_nxt = eff_lchars;
    linv_nxt   = eff_linv;
    left_nxt   = eff_left;
    inval_nxt  = eff_inval;
    named_nxt  = eff_named;
    esc_nxt    = eff_esc;
    case (eff_phase)
      PH_LEN: begin
        if (len_full) begin
          res[res_n] = mk_res(K_REJECT, 8'd0, ERR_FIELD_LONG);
          res_n = res_n + 2'd1;
        end else begin
          lchars_nxt = eff_lchars + 5'd1;
          if (is_colon) begin
            if (len_reject) begin
              res[res_n] = mk_res(K_REJECT, 8'd0, ERR_OVER_LIMIT);
              res_n = res_n + 2'd1;
            end else begin
              left_nxt  = len_eff;
              inval_nxt = 1'b0;
              named_nxt = 1'b0;
              esc_nxt   = ESC_NONE;
            end
          end else if (is_digit) begin
            lval_nxt = lval_sat;
          end else begin
            linv_nxt = 1'b1;
          end
        end
      end
      PH_BODY: begin
        if (body_last) begin
          esc_nxt = ESC_NONE;
          if (b == CH_COMMA) begin
            res[res_n] = mk_res(K_ACCEPT, 8'd0, ERR_FIELD_LONG);
          end else begin
            res[res_n] = mk_res(K_REJECT, 8'd0, ERR_NO_COMMA);
          end
          res_n = res_n + 2'd1;
        end else begin
          left_nxt = eff_left - LENGTH_BITS'(1);
          if (b == CH_NUL) begin
            if (eff_inval) begin
              // held escape text goes out before the value end
              if (e == ESC_PCT || e == ESC_PCT2) begin
                res[res_n] = mk_res(K_VALUE_BYTE, CH_PCT, ERR_FIELD_LONG);
                res_n = res_n + 2'd1;
              end
              if (e == ESC_PCT2) begin
                res[res_n] = mk_res(K_VALUE_BYTE, CH_TWO, ERR_FIELD_LONG);
                res_n = res_n + 2'd1;
              end
              res[res_n] = mk_res(K_VALUE_END, 8'd0, ERR_FIELD_LONG);
              res_n = res_n + 2'd1;
              inval_nxt = 1'b0;
              named_nxt = 1'b0;
              esc_nxt   = ESC_NONE;
            end else if (eff_named) begin
              res[res_n] = mk_res(K_NAME_END, 8'd0, ERR_FIELD_LONG);
              res_n = res_n + 2'd1;
              inval_nxt = 1'b1;
              esc_nxt   = ESC_NONE;
            end
          end else if (eff_inval) begin
            // value byte with %20 decoding
            case (e)
              ESC_PCT: begin
                if (b == CH_TWO) begin
                  esc_nxt = ESC_PCT2;
                  done = 1'b1;
                end else begin
                  res[res_n] = mk_res(K_VALUE_BYTE, CH_PCT, ERR_FIELD_LONG);
                  res_n = res_n + 2'd1;
                end
              end
              ESC_PCT2: begin
                if (b == CH_ZERO) begin
                  res[res_n] = mk_res(K_VALUE_BYTE, CH_SPACE, ERR_FIELD_LONG);
                  res_n = res_n + 2'd1;
                  esc_nxt = ESC_NONE;
                  done = 1'b1;
                end else begin
                  res[res_n] = mk_res(K_VALUE_BYTE, CH_PCT, ERR_FIELD_LONG);
                  res_n = res_n + 2'd1;
                  res[res_n] = mk_res(K_VALUE_BYTE, CH_TWO, ERR_FIELD_LONG);
                  res_n = res_n + 2'd1;
                end
              end
              default: done = 1'b0;
            endcase
            if (!done) begin
              if (b == CH_PCT && decode_r) begin
                esc_nxt = ESC_PCT;
              end else begin
                res[res_n] = mk_res(K_VALUE_BYTE, b, ERR_FIELD_LONG);
                res_n = res_n + 2'd1;
                esc_nxt = ESC_NONE;
              end
            end
          end else begin
            named_nxt = 1'b1;
            res[res_n] = mk_res(K_NAME_BYTE, b, ERR_FIELD_LONG);
            res_n = res_n + 2'd1;
          end
        end
      end
      default: res_n = '0;
    endcase
    // flag the final result of this byte
    if (res_n != '0) begin
      res[res_n - 2'd1].last = 1'b1;
    end
  end

  // Queue occupancy
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc) begin
      cnt_nxt = cnt_nxt + FIFO_CNT_W'(res_n);
    end
    if (out_acc) begin
      cnt_nxt = cnt_nxt - FIFO_CNT_W'(1);
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_body_r  <= MAX_BODY_RESET;
      max_chars_r <= MAX_CHARS_RESET;
      decode_r    <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MAX_BODY_LENGTH:  max_body_r  <= cfg_data[MAX_BODY_W-1:0];
        CFG_MAX_LENGTH_CHARS: max_chars_r <= cfg_data[MAX_CHARS_W-1:0];
        CFG_DECODE_SPACE:     decode_r    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Parser state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEN;
      lval_r   <= '0;
      lchars_r <= '0;
      linv_r   <= 1'b0;
      left_r   <= '0;
      inval_r  <= 1'b0;
      named_r  <= 1'b0;
      esc_r    <= ESC_NONE;
    end else if (in_acc) begin
      phase_r  <= phase_nxt;
      lval_r   <= lval_nxt;
      lchars_r <= lchars_nxt;
      linv_r   <= linv_nxt;
      left_r   <= left_nxt;
      inval_r  <= inval_nxt;
      named_r  <= named_nxt;
      esc_r    <= esc_nxt;
    end
  end

  // Queue pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_acc) begin
        wr_ptr_r <= wr_ptr_r + FIFO_AW'(res_n);
      end
      if (out_acc) begin
        rd_ptr_r <= rd_ptr_r + FIFO_AW'(1);
      end
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (in_acc) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
        if (2'(i) < res_n) begin
          fifo_r[wr_ptr_r + FIFO_AW'(i)] <= res[i];
        end
      end
    end
  end

`ifndef SYNTHESIS
  // queue never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  // an accepted byte always finds room for its worst case
  a_room: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> cnt_r + FIFO_CNT_W'(MAX_RESULTS) <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("byte accepted without room for its results");

  // escape stage never reaches the unused code
  a_esc: assert property (@(posedge clk) disable iff (!rst_n)
    esc_r != 2'd3)
    else $error("escape stage out of range");

  // once done, bytes without new_request produce nothing
  a_done_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && !in_data.new_request && phase_r == PH_DONE) |-> res_n == '0)
    else $error("result produced in done phase");

  // the queue count holds steady when nothing is pushed or popped
  a_cnt_track: assert property (@(posedge clk) disable iff (!rst_n)
    (!in_acc && !out_acc) |=> $stable(cnt_r))
    else $error("queue count changed without traffic");
`endif

endmodule
